// File: sv/pmdp_pkg.sv
package pmdp_pkg;

   // Default sizing
   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_BITS_DEF = 16;

   // Register widths
   localparam int TARGET_W = 11;
   localparam int DIST_W   = 32;
   localparam int TRIES_W  = 24;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;

   // Result word layout
   localparam int PIDX_W = 10;
   localparam int RSP_W  = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST_SQ  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TRIES    = 2'd2;

   // Register reset values
   localparam logic [TARGET_W-1:0] TARGET_RST = 11'd1;
   localparam logic [DIST_W-1:0]   DIST_RST   = 32'd0;
   localparam logic [TRIES_W-1:0]  TRIES_RST  = 24'd102400;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_AXIS,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      AX_X,
      AX_Y,
      AX_Z
   } axis_type;

   // Control from the sequencer to the distance unit
   typedef struct packed {
      logic clear;   // start of a new candidate
      logic valid;   // one axis operand pair this cycle
      logic first;   // first axis of a stored point
      logic last;    // last axis of a stored point
   } dist_ctl_type;

endpackage

// File: sv/pmdp_dist.sv
module pmdp_dist
   import pmdp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dist_ctl_type            ctl,
   input  logic [COORD_BITS-1:0]   stored_coord,
   input  logic [COORD_BITS-1:0]   cand_coord,
   input  logic [DIST_W-1:0]       min_dist_sq,
   output logic                    busy,
   output logic                    hit
);

   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int ACC_W = SQ_W + 2;
   localparam int CMP_W = (ACC_W > DIST_W) ? ACC_W : DIST_W;

   logic [COORD_BITS-1:0] diff;
   logic [COORD_BITS-1:0] mag;

   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic             sq_v_ff, sq_v_in;
   logic             sq_first_ff, sq_first_in;
   logic             sq_last_ff, sq_last_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] sum;
   logic             hit_ff, hit_in;

   // Two's-complement wrap of the difference is the periodic fold
   always_comb begin
      diff        = stored_coord - cand_coord;
      mag         = diff[COORD_BITS-1] ? (~diff + COORD_BITS'(1)) : diff;
      sq_in       = SQ_W'(mag) * SQ_W'(mag);
      sq_v_in     = ctl.valid;
      sq_first_in = ctl.first;
      sq_last_in  = ctl.last;
   end

   // Accumulate the axis squares, compare at the last axis
   always_comb begin
      sum    = (sq_first_ff ? '0 : acc_ff) + ACC_W'(sq_ff);
      acc_in = acc_ff;
      hit_in = hit_ff;
      if (ctl.clear) begin
         hit_in = 1'b0;
      end else if (sq_v_ff) begin
         acc_in = sum;
         if (sq_last_ff && (CMP_W'(sum) <= CMP_W'(min_dist_sq))) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sq_ff       <= sq_in;
      sq_first_ff <= sq_first_in;
      sq_last_ff  <= sq_last_in;
      acc_ff      <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         sq_v_ff <= sq_v_in;
         hit_ff  <= hit_in;
      end
   end

   assign busy = sq_v_ff;
   assign hit  = hit_ff;

endmodule

// File: sv/periodic_min_distance_placer.sv
// Channel  Dir  Handshake            Word contents (lowest bit up)
// req      in   req_tvalid/tready    cand_x, cand_y, cand_z (signed COORD_BITS each)
// rsp      out  rsp_tvalid/tready    accepted, point_index, too_many_tries, all_placed
// csr      in   csr_we               csr_index selects the register, csr_wdata the value
//
// A candidate checked against the stored points passes the accept state, then for each point
// a fetch and three axis steps on the one shared squarer, then the drain and the result
// state. Ignored words, try-limit refusals, a zero threshold or an empty store go from the
// accept state straight to the result state. Reset is synchronous; it clears the count, try
// counter, failure flag and registers, but not the point store: only entries below the count
// are read. req_tready is high only while idle; a waiting result word holds DONE.
module periodic_min_distance_placer
   import pmdp_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // cand_x, cand_y, cand_z, zero fill
   input  logic [((3*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // accepted, point_index[9:0], too_many_tries, all_placed, zero fill
   output logic [RSP_W-1:0]                       rsp_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_we,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [CSR_W-1:0]                       csr_wdata
);

   localparam int PT_W  = 3 * COORD_BITS;
   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int TGT_W = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;
   localparam logic [TGT_W-1:0] MAX_TGT = TGT_W'(MAX_POINTS);

   // Configuration registers
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [DIST_W-1:0]   min_dist_ff, min_dist_in;
   logic [TRIES_W-1:0]  max_tries_ff, max_tries_in;

   // Placement state
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TRIES_W-1:0]  try_ff, try_in;
   logic                failed_ff, failed_in;

   // Sequencer
   state_type           state_ff, state_in;
   axis_type            ax_ff, ax_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic                live_ff, live_in;
   logic                rej_ff, rej_in;
   logic [PT_W-1:0]     cand_ff, cand_in;

   // Output register
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Point store
   logic [PT_W-1:0]     store_mem [MAX_POINTS];
   logic [PT_W-1:0]     rd_data_ff;
   logic                store_we;

   logic [TGT_W-1:0]    eff_tgt;
   logic                req_fire;
   logic                out_free;
   logic                last_point;
   logic                store_ok;
   logic [CNT_W-1:0]    count_after;
   logic [TRIES_W-1:0]  try_bump;
   logic [COORD_BITS-1:0] stored_sel, cand_sel;

   dist_ctl_type        dist_ctl;
   logic                dist_busy;
   logic                dist_hit;

   // Configuration writes
   always_comb begin
      target_in    = target_ff;
      min_dist_in  = min_dist_ff;
      max_tries_in = max_tries_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_COUNT: target_in    = csr_wdata[TARGET_W-1:0];
            CSR_MIN_DIST_SQ:  min_dist_in  = csr_wdata[DIST_W-1:0];
            CSR_MAX_TRIES:    max_tries_in = csr_wdata[TRIES_W-1:0];
            default:          ;
         endcase
      end
   end

   // Saturate the target to the store depth
   always_comb begin
      eff_tgt = (TGT_W'(target_ff) > MAX_TGT) ? MAX_TGT : TGT_W'(target_ff);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_point = ((CNT_W'(ptr_ff) + CNT_W'(1)) == count_ff);
   assign store_ok   = live_ff && !rej_ff && !dist_hit;
   assign count_after = count_ff + CNT_W'(store_ok);
   assign try_bump   = (try_ff != '1) ? (try_ff + TRIES_W'(1)) : try_ff;
   assign store_we   = (state_ff == ST_DONE) && out_free && store_ok;

   // Pick the axis that the distance unit works on this cycle
   always_comb begin
      unique case (ax_ff)
         AX_X: begin
            stored_sel = rd_data_ff[COORD_BITS-1:0];
            cand_sel   = cand_ff[COORD_BITS-1:0];
         end
         AX_Y: begin
            stored_sel = rd_data_ff[2*COORD_BITS-1:COORD_BITS];
            cand_sel   = cand_ff[2*COORD_BITS-1:COORD_BITS];
         end
         AX_Z: begin
            stored_sel = rd_data_ff[3*COORD_BITS-1:2*COORD_BITS];
            cand_sel   = cand_ff[3*COORD_BITS-1:2*COORD_BITS];
         end
         default: begin
            stored_sel = rd_data_ff[COORD_BITS-1:0];
            cand_sel   = cand_ff[COORD_BITS-1:0];
         end
      endcase
   end

   // Sequencer: next state and outputs
   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      ptr_in       = ptr_ff;
      live_in      = live_ff;
      rej_in       = rej_ff;
      cand_in      = cand_ff;
      count_in     = count_ff;
      try_in       = try_ff;
      failed_in    = failed_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      dist_ctl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cand_in        = req_tdata[PT_W-1:0];
               dist_ctl.clear = 1'b1;
               ptr_in         = '0;
               ax_in          = AX_X;
               live_in        = !failed_ff && (TGT_W'(count_ff) < eff_tgt);
               rej_in         = 1'b0;
               state_in       = ST_DONE;
               if (live_in) begin
                  try_in = try_bump;
                  if (try_bump > max_tries_ff) begin
                     // Try limit passed: refuse and latch the failure
                     rej_in    = 1'b1;
                     failed_in = 1'b1;
                  end else if ((min_dist_ff != '0) && (count_ff != '0)) begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            ax_in    = AX_X;
            state_in = ST_AXIS;
         end
         ST_AXIS: begin
            dist_ctl.valid = 1'b1;
            dist_ctl.first = (ax_ff == AX_X);
            dist_ctl.last  = (ax_ff == AX_Z);
            unique case (ax_ff)
               AX_X: ax_in = AX_Y;
               AX_Y: ax_in = AX_Z;
               AX_Z: begin
                  ax_in = AX_X;
                  if (last_point) begin
                     state_in = ST_DRAIN;
                  end else begin
                     ptr_in   = ptr_ff + IDX_W'(1);
                     state_in = ST_FETCH;
                  end
               end
               default: ax_in = AX_X;
            endcase
         end
         ST_DRAIN: begin
            // Wait for the last sum to land in the hit flag
            if (!dist_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               if (store_ok) begin
                  count_in = count_after;
                  try_in   = '0;
               end
               rsp_data_in = RSP_W'({(TGT_W'(count_after) >= eff_tgt),
                                     failed_ff,
                                     PIDX_W'(count_ff),
                                     store_ok});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TARGET_RST;
         min_dist_ff  <= DIST_RST;
         max_tries_ff <= TRIES_RST;
         count_ff     <= '0;
         try_ff       <= '0;
         failed_ff    <= 1'b0;
         state_ff     <= ST_IDLE;
         ax_ff        <= AX_X;
         ptr_ff       <= '0;
         live_ff      <= 1'b0;
         rej_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         min_dist_ff  <= min_dist_in;
         max_tries_ff <= max_tries_in;
         count_ff     <= count_in;
         try_ff       <= try_in;
         failed_ff    <= failed_in;
         state_ff     <= state_in;
         ax_ff        <= ax_in;
         ptr_ff       <= ptr_in;
         live_ff      <= live_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Point store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[count_ff[IDX_W-1:0]] <= cand_ff;
      end
      rd_data_ff <= store_mem[ptr_ff];
   end

   pmdp_dist #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock        (clock),
      .reset        (reset),
      .ctl          (dist_ctl),
      .stored_coord (stored_sel),
      .cand_coord   (cand_sel),
      .min_dist_sq  (min_dist_ff),
      .busy         (dist_busy),
      .hit          (dist_hit)
   );

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   // Storing a point restarts the try counter and advances the count by one
   a_store_restarts: assert property (@(posedge clock) disable iff (reset)
      store_we |=> (try_ff == '0) && (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("store did not restart tries or advance count");

   // Failure never clears outside reset
   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> failed_ff)
      else $error("failure flag dropped");

   // No distance work is in flight once a new candidate may enter
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !dist_busy)
      else $error("distance unit busy while idle");

   // The count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(MAX_POINTS) >= count_ff)
      else $error("point count beyond store depth");
`endif

endmodule

// File: test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pmdp_pkg::*;

   localparam int MAXP = MAX_POINTS_DEF;
   localparam int CBITS = COORD_BITS_DEF;
   localparam int REQ_W = ((3 * CBITS + 7) / 8) * 8;
   // Longest correct silence: one candidate against a full store, plus a slow receiver.
   localparam int STALL_LIMIT = 50000;
   // Index with no register behind it; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   // One candidate word, x in the lowest bits.
   typedef struct packed {
      logic [CBITS-1:0] z;
      logic [CBITS-1:0] y;
      logic [CBITS-1:0] x;
   } cand_type;

   typedef struct packed {
      logic              all_placed;
      logic              too_many_tries;
      logic [PIDX_W-1:0] point_index;
      logic              accepted;
   } placement_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   periodic_min_distance_placer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),   // cand_x, cand_y, cand_z
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),   // accepted, point_index, too_many_tries, all_placed
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Placement predictor: own copy of registers, point store and counters
   // ---------------------------------------------------------------------
   logic [TARGET_W-1:0] cfg_target    = TARGET_RST;
   logic [DIST_W-1:0]   cfg_min_sq    = DIST_RST;
   logic [TRIES_W-1:0]  cfg_max_tries = TRIES_RST;

   logic [CBITS-1:0]    kept_x [MAXP];
   logic [CBITS-1:0]    kept_y [MAXP];
   logic [CBITS-1:0]    kept_z [MAXP];
   int unsigned         n_placed = 0;
   logic [TRIES_W-1:0]  n_tries  = '0;
   bit                  gave_up  = 1'b0;

   cand_type            candidates[$];      // words waiting to be sent
   placement_type       placements_due[$];  // results owed by the block, oldest first

   int                  send_idle_pct  = 0;
   int                  recv_stall_pct = 0;
   bit                  req_taken = 1'b0;
   int                  mismatches = 0;
   int                  words_seen = 0;
   int                  quiet = 0;

   // Squared separation along one axis; the two's-complement wrap folds the box.
   function automatic logic [33:0] wrap_sq(logic [CBITS-1:0] a, logic [CBITS-1:0] b);
      logic [CBITS-1:0] d;
      logic [CBITS:0]   mag;
      d   = a - b;
      mag = d[CBITS-1] ? ((17'h1 << CBITS) - {1'b0, d}) : {1'b0, d};
      return mag * mag;
   endfunction

   function automatic placement_type place_candidate(logic [CBITS-1:0] cx,
                                                     logic [CBITS-1:0] cy,
                                                     logic [CBITS-1:0] cz);
      placement_type res;
      int unsigned   tgt;
      bit            ok;
      logic [63:0]   d2;
      tgt = (cfg_target > MAXP) ? MAXP : cfg_target;
      res = '0;
      res.point_index = n_placed[PIDX_W-1:0];
      if (!gave_up && n_placed < tgt) begin
         ok = 1'b1;
         if (n_tries != {TRIES_W{1'b1}})
            n_tries++;
         if (n_tries > cfg_max_tries) begin
            // try limit passed: refuse and stick until reset
            gave_up = 1'b1;
            ok      = 1'b0;
         end else if (cfg_min_sq != 0) begin
            for (int j = 0; j < n_placed; j++) begin
               d2 = wrap_sq(kept_x[j], cx) + wrap_sq(kept_y[j], cy) + wrap_sq(kept_z[j], cz);
               if (d2 <= {32'd0, cfg_min_sq})
                  ok = 1'b0;
            end
         end
         if (ok && n_placed < MAXP) begin
            kept_x[n_placed] = cx;
            kept_y[n_placed] = cy;
            kept_z[n_placed] = cz;
            n_placed++;
            n_tries = '0;
            res.accepted = 1'b1;
         end
      end
      res.too_many_tries = gave_up;
      res.all_placed     = (n_placed >= tgt);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: change at the falling edge, hold a word until taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : req_accept
      if (!reset && req_tvalid && req_tready) begin
         placements_due.insert(placements_due.size(),
                               place_candidate(req_tdata[CBITS-1:0],
                                               req_tdata[2*CBITS-1:CBITS],
                                               req_tdata[3*CBITS-1:2*CBITS]));
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin : req_drive
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         // advance to the next word unless the sender idles this cycle
         if (candidates.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tdata  <= candidates.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: stall at random, compare each word with the oldest due
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : rsp_drive
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : rsp_check
      placement_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (placements_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: word %h arrived with nothing due", words_seen, rsp_tdata);
         end else begin
            want = placements_due.pop_front();
            // bit 0 accepted, 10:1 point_index, 11 too_many_tries, 12 all_placed
            if (rsp_tdata[0] !== want.accepted ||
                rsp_tdata[PIDX_W:1] !== want.point_index ||
                rsp_tdata[PIDX_W+1] !== want.too_many_tries ||
                rsp_tdata[PIDX_W+2] !== want.all_placed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: exp acc %0b idx %0d fail %0b done %0b, got %0b %0d %0b %0b",
                           words_seen, want.accepted, want.point_index, want.too_many_tries,
                           want.all_placed, rsp_tdata[0], rsp_tdata[PIDX_W:1],
                           rsp_tdata[PIDX_W+1], rsp_tdata[PIDX_W+2]);
            end
         end
      end
   end

   // Drop the run if nothing moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet = 0;
      else
         quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic set_idle(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SEND: begin send_idle_pct = 80; recv_stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 80; end
         default:   begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
   endtask

   // Write one register and mirror it into the predictor; only called while idle.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TARGET_COUNT: cfg_target    = val[TARGET_W-1:0];
         CSR_MIN_DIST_SQ:  cfg_min_sq    = val[DIST_W-1:0];
         CSR_MAX_TRIES:    cfg_max_tries = val[TRIES_W-1:0];
         default: ;
      endcase
   endtask

   // Hold until every word is sent and every result is back, then let the block rest.
   task automatic settle();
      while (candidates.size() != 0 || req_tvalid || placements_due.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Append one word to the send queue.
   task automatic add_cand(cand_type c);
      candidates.insert(candidates.size(), c);
   endtask

   task automatic push_cand(logic [CBITS-1:0] x, logic [CBITS-1:0] y, logic [CBITS-1:0] z);
      cand_type c;
      c.x = x;
      c.y = y;
      c.z = z;
      add_cand(c);
   endtask

   function automatic cand_type any_cand();
      cand_type c;
      c.x = CBITS'($urandom);
      c.y = CBITS'($urandom);
      c.z = CBITS'($urandom);
      return c;
   endfunction

   function automatic logic [CBITS-1:0] corner_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h0001;
         default: return CBITS'($urandom);
      endcase
   endfunction

   function automatic logic [CBITS-1:0] nudge(logic [CBITS-1:0] v, int r);
      int off;
      off = int'($urandom_range(0, 2 * r)) - r;
      return v + off[CBITS-1:0];
   endfunction

   // A stored point moved by a random offset, or one axis moved to the boundary
   // of the threshold (on it or one step beyond).
   function automatic cand_type near_point(int r);
      cand_type c;
      int       j;
      int       k;
      j   = $urandom_range(0, n_placed - 1);
      c.x = kept_x[j];
      c.y = kept_y[j];
      c.z = kept_z[j];
      if ($urandom_range(0, 3) == 0) begin
         k = r + int'($urandom_range(0, 1));
         if ($urandom_range(0, 1) == 1)
            k = -k;
         case ($urandom_range(0, 2))
            0: c.x = c.x + k[CBITS-1:0];
            1: c.y = c.y + k[CBITS-1:0];
            default: c.z = c.z + k[CBITS-1:0];
         endcase
      end else begin
         c.x = nudge(c.x, r);
         c.y = nudge(c.y, r);
         c.z = nudge(c.z, r);
      end
      return c;
   endfunction

   task automatic queue_random(int count, int r);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50 && n_placed > 0)
            add_cand(near_point(r));
         else if (pick < 85)
            add_cand(any_cand());
         else
            push_cand(corner_coord(), corner_coord(), corner_coord());
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : sequence_main
      int                  r;
      logic [DIST_W-1:0]   min_sq;
      logic [CSR_W-1:0]    word;
      logic [TARGET_W-1:0] tgt;
      logic [TRIES_W-1:0]  mt;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default registers: first point goes in, then the run counts as complete.
      set_idle(IDLE_NONE);
      push_cand(16'h0000, 16'h0000, 16'h0000);
      push_cand(16'h8000, 16'h7FFF, 16'hFFFF);
      settle();

      // Zero target: complete at once, items ignored.
      csr_write(CSR_TARGET_COUNT, '0);
      push_cand(16'd100, 16'hFF9C, 16'd5);
      settle();

      // Antipode of the origin sits exactly at the largest possible distance.
      csr_write(CSR_TARGET_COUNT, 32'h0000_07FF);
      csr_write(CSR_MIN_DIST_SQ, 32'd3221225472);
      push_cand(16'h8000, 16'h8000, 16'h8000);
      settle();
      csr_write(CSR_MIN_DIST_SQ, 32'd3221225471);
      push_cand(16'h8000, 16'h8000, 16'h8000);
      settle();

      // Wrap across the box edge: one step on each axis from the antipode.
      csr_write(CSR_MIN_DIST_SQ, 32'd3);
      push_cand(16'h7FFF, 16'h7FFF, 16'h7FFF);
      settle();
      csr_write(CSR_MIN_DIST_SQ, 32'd2);
      push_cand(16'h7FFF, 16'h7FFF, 16'h7FFF);
      settle();

      // Zero threshold takes even a duplicate.
      csr_write(CSR_MIN_DIST_SQ, '0);
      push_cand(16'h8000, 16'h8000, 16'h8000);
      push_cand(16'h7FFF, 16'h8000, 16'h0000);
      settle();

      // Try limit of three: two refusals, then a take on the third try.
      csr_write(CSR_MAX_TRIES, 32'd3);
      csr_write(CSR_MIN_DIST_SQ, 32'hFFFF_FFFF);
      add_cand(any_cand());
      add_cand(any_cand());
      settle();
      csr_write(CSR_MIN_DIST_SQ, '0);
      add_cand(any_cand());
      settle();

      // Targets at and past the store size saturate; the spare index does nothing.
      csr_write(CSR_TARGET_COUNT, 32'd1024);
      csr_write(CSR_UNUSED, $urandom);
      csr_write(CSR_MAX_TRIES, 32'h00FF_FFFF);
      add_cand(any_cand());
      settle();
      csr_write(CSR_TARGET_COUNT, 32'd1025);
      add_cand(any_cand());
      settle();

      // Random phases; keep the target close to the count, but for phase 3, so compares stay short.
      for (int p = 0; p < 8; p++) begin
         set_idle(idle_mode_type'(p % 4));
         case (p)
            2: begin r = 100; min_sq = '0; end
            5: begin r = 1000; min_sq = $urandom; end
            6: begin r = $urandom_range(8000, 20000); min_sq = r * r; end
            default: begin r = $urandom_range(1, 3000); min_sq = r * r; end
         endcase
         if (p == 3)
            tgt = TARGET_W'(1024 + $urandom_range(0, 1023));
         else
            tgt = TARGET_W'(n_placed + $urandom_range(10, 40));
         // junk in the bits above each register must be dropped
         word = $urandom;
         csr_write(CSR_TARGET_COUNT, {word[CSR_W-1:TARGET_W], tgt});
         csr_write(CSR_MIN_DIST_SQ, min_sq);
         mt   = (p == 0) ? {TRIES_W{1'b1}} : TRIES_W'($urandom_range(1000, 24'hFF_FFFF));
         word = $urandom;
         csr_write(CSR_MAX_TRIES, {word[CSR_W-1:TRIES_W], mt});
         queue_random(70, r);
         settle();
      end

      // Last: a tiny try limit with everything refused; the failure then sticks.
      set_idle(IDLE_BOTH);
      csr_write(CSR_TARGET_COUNT, 32'h0000_07FF);
      csr_write(CSR_MIN_DIST_SQ, 32'hFFFF_FFFF);
      word = $urandom;
      mt   = TRIES_W'($urandom_range(0, 3));
      csr_write(CSR_MAX_TRIES, {word[CSR_W-1:TRIES_W], mt});
      for (int i = 0; i < 8; i++)
         add_cand(any_cand());
      settle();

      if (mismatches == 0 && placements_due.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
